/* hw/rtl/sbd_pkg.sv */
package sbd_pkg;

   // largest block side the counters and sums are sized for
   localparam int MAX_SIDE = 128;

   localparam int PIX_W  = 8;
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int AREA_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int CNT_W  = AREA_W;
   localparam int SUM_W  = $clog2(MAX_SIDE * MAX_SIDE * 255 + 1);
   localparam int SQ_W   = 2 * PIX_W;
   localparam int CB_W   = 3 * PIX_W;
   localparam int CUBE_W = $clog2(64'(MAX_SIDE) * 64'(MAX_SIDE) * 64'd16581375 + 64'd1);
   localparam int STR_W  = 10;
   localparam int AT3_W  = AREA_W + CB_W;
   localparam int LIM_W  = AT3_W + STR_W;
   localparam int STR_SHIFT = 8;
   localparam int CMP_W  = LIM_W - STR_SHIFT;

   // datapath stages between capture and commit
   localparam int PIPE_DEPTH = 5;
   localparam int WAIT_W     = $clog2(PIPE_DEPTH);

   // configuration port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   localparam logic [7:0] BLOCK_SIDE_RST    = 8'd8;
   localparam logic [7:0] THRESHOLD_RST     = 8'd4;
   localparam logic [9:0] STRENGTH_RST      = 10'd256;
   localparam logic       FILTER_ENABLE_RST = 1'b1;

   typedef enum logic [1:0] {
      CSR_BLOCK_SIDE,
      CSR_THRESHOLD,
      CSR_STRENGTH,
      CSR_FILTER_ENABLE
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [7:0] block_side;
      logic [7:0] threshold;
      logic [9:0] strength;
      logic       filter_enable;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

/* hw/rtl/sbd_req_if.sv */
interface sbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] current_pixel;
   logic [7:0] previous_pixel;
   logic [7:0] old_filtered;

   modport source (output valid, current_pixel, previous_pixel, old_filtered, input ready);
   modport sink   (input valid, current_pixel, previous_pixel, old_filtered, output ready);
endinterface

/* hw/rtl/sbd_rsp_if.sv */
interface sbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] new_filtered;
   logic       is_static;
   logic       last;

   modport source (output valid, new_filtered, is_static, last, input ready);
   modport sink   (input valid, new_filtered, is_static, last, output ready);
endinterface

/* hw/rtl/sbd_csr.sv */
module sbd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sbd_pkg::ADDR_W-1:0] paddr,
   input  logic [sbd_pkg::DATA_W-1:0] pwdata,
   output logic [sbd_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output sbd_pkg::cfg_type           cfg
);

   sbd_pkg::cfg_type       cfg_ff;
   sbd_pkg::cfg_type       cfg_in;
   sbd_pkg::csr_index_type index;
   logic                   wr_en;

   assign pready = 1'b1;
   assign index  = sbd_pkg::csr_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            sbd_pkg::CSR_BLOCK_SIDE:    cfg_in.block_side    = pwdata[7:0];
            sbd_pkg::CSR_THRESHOLD:     cfg_in.threshold     = pwdata[7:0];
            sbd_pkg::CSR_STRENGTH:      cfg_in.strength      = pwdata[9:0];
            sbd_pkg::CSR_FILTER_ENABLE: cfg_in.filter_enable = pwdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         sbd_pkg::CSR_BLOCK_SIDE:    prdata[7:0] = cfg_ff.block_side;
         sbd_pkg::CSR_THRESHOLD:     prdata[7:0] = cfg_ff.threshold;
         sbd_pkg::CSR_STRENGTH:      prdata[9:0] = cfg_ff.strength;
         sbd_pkg::CSR_FILTER_ENABLE: prdata[0]   = cfg_ff.filter_enable;
         default:                    prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_side    <= sbd_pkg::BLOCK_SIDE_RST;
         cfg_ff.threshold     <= sbd_pkg::THRESHOLD_RST;
         cfg_ff.strength      <= sbd_pkg::STRENGTH_RST;
         cfg_ff.filter_enable <= sbd_pkg::FILTER_ENABLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/sbd_ctrl.sv */
module sbd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbd_pkg::cmd_type cmd
);

   sbd_pkg::state_type        state_ff, state_in;
   logic [sbd_pkg::WAIT_W-1:0] wait_ff, wait_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         sbd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = sbd_pkg::ST_BUSY;
               wait_in  = '0;
            end
         end
         sbd_pkg::ST_BUSY: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == sbd_pkg::WAIT_W'(sbd_pkg::PIPE_DEPTH - 1)) begin
               state_in = sbd_pkg::ST_COMMIT;
            end
         end
         sbd_pkg::ST_COMMIT: begin
            // output register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sbd_pkg::ST_IDLE;
            end
         end
         default: state_in = sbd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbd_pkg::ST_IDLE;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/sbd_datapath.sv */
module sbd_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sbd_pkg::cmd_type cmd,
   input  sbd_pkg::cfg_type cfg,
   input  logic [7:0]       current_pixel,
   input  logic [7:0]       previous_pixel,
   input  logic [7:0]       old_filtered,
   output logic [7:0]       new_filtered,
   output logic             is_static,
   output logic             last
);

   // captured beat
   logic [7:0] cur_ff, prev_ff, old_ff;

   // block accumulators
   logic [sbd_pkg::CUBE_W-1:0] cube_sum_ff;
   logic [sbd_pkg::SUM_W-1:0]  cur_sum_ff, prev_sum_ff;
   logic [sbd_pkg::CNT_W-1:0]  count_ff;

   // stage a
   logic [7:0]                 ad_a_ff, filt_a_ff;
   logic [sbd_pkg::AREA_W-1:0] area_a_ff;
   logic [sbd_pkg::SQ_W-1:0]   t2_a_ff;
   logic [sbd_pkg::SUM_W-1:0]  cur_nx_a_ff, prev_nx_a_ff;
   // stage b
   logic [sbd_pkg::SQ_W-1:0]   ad2_b_ff;
   logic [sbd_pkg::CB_W-1:0]   t3_b_ff;
   logic                       last_b_ff;
   logic [sbd_pkg::SUM_W-1:0]  sd_b_ff;
   // stage c
   logic [sbd_pkg::CB_W-1:0]   cube_c_ff;
   logic [sbd_pkg::AT3_W-1:0]  at3_c_ff;
   logic                       sd_ok_c_ff;
   // stage d
   logic [sbd_pkg::CUBE_W-1:0] cube_nx_d_ff;
   logic [sbd_pkg::LIM_W-1:0]  lim_d_ff;
   // stage e
   logic                       stat_e_ff;
   // result register
   logic [7:0]                 new_filtered_ff;
   logic                       is_static_ff, last_ff;

   logic [sbd_pkg::SIDE_W-1:0] side;
   logic [sbd_pkg::AREA_W-1:0] side_ext;
   logic [7:0]                 ad;
   logic [3:0]                 w;
   logic [10:0]                blend;

   always_comb begin
      if (cfg.block_side == 8'd0) begin
         side = sbd_pkg::SIDE_W'(1);
      end else if (int'(cfg.block_side) > sbd_pkg::MAX_SIDE) begin
         side = sbd_pkg::SIDE_W'(sbd_pkg::MAX_SIDE);
      end else begin
         side = sbd_pkg::SIDE_W'(cfg.block_side);
      end
      side_ext = sbd_pkg::AREA_W'(side);
      ad       = (cur_ff > prev_ff) ? cur_ff - prev_ff : prev_ff - cur_ff;
      w        = (ad < 8'd7) ? ad[3:0] + 4'd1 : 4'd8;
      blend    = 11'(w) * 11'(cur_ff) + 11'(4'd8 - w) * 11'(old_ff) + 11'd4;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff  <= current_pixel;
         prev_ff <= previous_pixel;
         old_ff  <= old_filtered;
      end

      // stages run freely off the held beat and accumulators
      ad_a_ff      <= ad;
      filt_a_ff    <= blend[10:3];
      area_a_ff    <= side_ext * side_ext;
      t2_a_ff      <= sbd_pkg::SQ_W'(cfg.threshold) * sbd_pkg::SQ_W'(cfg.threshold);
      cur_nx_a_ff  <= cur_sum_ff + sbd_pkg::SUM_W'(cur_ff);
      prev_nx_a_ff <= prev_sum_ff + sbd_pkg::SUM_W'(prev_ff);

      ad2_b_ff  <= sbd_pkg::SQ_W'(ad_a_ff) * sbd_pkg::SQ_W'(ad_a_ff);
      t3_b_ff   <= sbd_pkg::CB_W'(t2_a_ff) * sbd_pkg::CB_W'(cfg.threshold);
      last_b_ff <= ({1'b0, count_ff} + 1'b1) >= {1'b0, area_a_ff};
      sd_b_ff   <= (cur_nx_a_ff > prev_nx_a_ff) ? cur_nx_a_ff - prev_nx_a_ff
                                                : prev_nx_a_ff - cur_nx_a_ff;

      cube_c_ff  <= sbd_pkg::CB_W'(ad2_b_ff) * sbd_pkg::CB_W'(ad_a_ff);
      at3_c_ff   <= sbd_pkg::AT3_W'(t3_b_ff) * sbd_pkg::AT3_W'(area_a_ff);
      sd_ok_c_ff <= sd_b_ff < sbd_pkg::SUM_W'(area_a_ff);

      cube_nx_d_ff <= cube_sum_ff + sbd_pkg::CUBE_W'(cube_c_ff);
      lim_d_ff     <= sbd_pkg::LIM_W'(at3_c_ff) * sbd_pkg::LIM_W'(cfg.strength);

      stat_e_ff <= sd_ok_c_ff &&
                   (sbd_pkg::CMP_W'(cube_nx_d_ff) < lim_d_ff[sbd_pkg::LIM_W-1:sbd_pkg::STR_SHIFT]);

      if (cmd.commit) begin
         new_filtered_ff <= cfg.filter_enable ? filt_a_ff : old_ff;
         is_static_ff    <= last_b_ff & stat_e_ff;
         last_ff         <= last_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_sum_ff <= '0;
         cur_sum_ff  <= '0;
         prev_sum_ff <= '0;
         count_ff    <= '0;
      end else if (cmd.commit) begin
         if (last_b_ff) begin
            cube_sum_ff <= '0;
            cur_sum_ff  <= '0;
            prev_sum_ff <= '0;
            count_ff    <= '0;
         end else begin
            cube_sum_ff <= cube_nx_d_ff;
            cur_sum_ff  <= cur_nx_a_ff;
            prev_sum_ff <= prev_nx_a_ff;
            count_ff    <= count_ff + 1'b1;
         end
      end
   end

   assign new_filtered = new_filtered_ff;
   assign is_static    = is_static_ff;
   assign last         = last_ff;

endmodule

/* hw/rtl/static_block_detect_temporal_filter_top.sv */
// one pixel in flight at a time; a beat is captured, walks the 5-stage
// multiply pipeline (cube of |c-p| and area*t^3*strength), then commits
// a waiting response stalls the commit until rsp_ready frees the output register
// reset (synchronous, active high) clears the accumulators, the sequencer and
// the response valid, and loads the register defaults side 8, t 4, strength 256, filter on
module static_block_detect_temporal_filter_top (
   input  logic                       clock,
   input  logic                       reset,
   sbd_req_if.sink                    req_chan,
   sbd_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sbd_pkg::ADDR_W-1:0] paddr,
   input  logic [sbd_pkg::DATA_W-1:0] pwdata,
   output logic [sbd_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   sbd_pkg::cfg_type cfg;
   sbd_pkg::cmd_type cmd;

   // register file: side, threshold, strength, filter enable
   sbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: capture, wait for the pipeline to settle, commit
   sbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // filter blend, cube/sum accumulation and static decision
   sbd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .current_pixel  (req_chan.current_pixel),
      .previous_pixel (req_chan.previous_pixel),
      .old_filtered   (req_chan.old_filtered),
      .new_filtered   (rsp_chan.new_filtered),
      .is_static      (rsp_chan.is_static),
      .last           (rsp_chan.last)
   );

   // a commit never overwrites a response that is still held
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("commit while response register occupied");

   // one beat in flight: no request taken in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a beat is in flight");

   // the static flag only comes with the closing pixel of a block
   a_static_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_static) |-> rsp_chan.last)
      else $error("static flag on a pixel that is not last");

endmodule
